// ===== rtl/core/fdtd_pkg.sv =====
`default_nettype none

package fdtd_pkg;

    typedef logic signed [31:0] sword_t;
    typedef logic [31:0]        uword_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_REQ,
        ST_RDC,
        ST_DIV_E,
        ST_DIV_M,
        ST_WCELL,
        ST_EB_RD,
        ST_EB_DIF,
        ST_EB_MUL,
        ST_EB_SAT,
        ST_EB_CURL,
        ST_EB_ACC,
        ST_EB_WR,
        ST_MIR_RD,
        ST_MIR_WR,
        ST_DONE
    } state_t;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    localparam logic [2:0] REG_DT        = 3'd0;
    localparam logic [2:0] REG_INV_DX    = 3'd1;
    localparam logic [2:0] REG_INV_DY    = 3'd2;
    localparam logic [2:0] REG_INV_DZ    = 3'd3;
    localparam logic [2:0] REG_SIZE_X    = 3'd4;
    localparam logic [2:0] REG_SIZE_Y    = 3'd5;
    localparam logic [2:0] REG_SIZE_Z    = 3'd6;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam int LN_EX   = 0;
    localparam int LN_BX   = 3;
    localparam int LN_IEPS = 6;
    localparam int LN_IMU  = 7;

    localparam uword_t Q_ONE   = 32'h0001_0000;
    localparam sword_t SW_MAX  = 32'sh7FFF_FFFF;
    localparam sword_t SW_MIN  = 32'sh8000_0000;

    function automatic sword_t sat33(input logic signed [32:0] s);
        sword_t r;
        if (s[32] != s[31]) begin
            r = s[32] ? SW_MIN : SW_MAX;
        end
        else begin
            r = s[31:0];
        end
        return r;
    endfunction

    function automatic sword_t add_sat(input sword_t a, input sword_t b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic sword_t sub_sat(input sword_t a, input sword_t b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    function automatic sword_t neg_sat(input sword_t v);
        sword_t r;
        if (v == SW_MIN) begin
            r = SW_MAX;
        end
        else begin
            r = -v;
        end
        return r;
    endfunction

    // floor(p / 2^16) clamped to 32 bits
    function automatic sword_t sat_prod(input logic signed [64:0] p);
        sword_t r;
        if (!p[64] && (|p[63:47])) begin
            r = SW_MAX;
        end
        else if (p[64] && !(&p[63:47])) begin
            r = SW_MIN;
        end
        else begin
            r = p[47:16];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fdtd_recip.sv =====
`default_nettype none

module fdtd_recip (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire fdtd_pkg::uword_t den,
    output fdtd_pkg::uword_t    quot,
    output logic                done
);
    import fdtd_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sat_reg;
    uword_t      den_reg;
    uword_t      rem_reg;
    uword_t      quo_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // dividend is 2^32: its only set bit enters on the first iteration
    assign trial = {rem_reg, (cnt_reg == 6'd33)};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd33;
        end
        else if (busy_reg) begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            den_reg <= den;
            sat_reg <= (den < 32'd2);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign quot = sat_reg ? 32'hFFFF_FFFF : quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fdtd_yee_field_update_top.sv =====
// write: two reciprocal divisions, then one cell write; read: one memory read
// step: per updated cell, four memory reads, twelve products through one shared
//   multiplier and one write, plus a read and a write per face mirror cell
// one item at a time; the next item is taken while a result waits at the output
// reset: a clearing pass loads every cell before the first item is taken;
//   configuration returns to its reset values at once
`default_nettype none

module fdtd_yee_field_update_top #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [3:0]         cell_x,
    input  wire logic [3:0]         cell_y,
    input  wire logic [3:0]         cell_z,
    input  wire logic signed [31:0] ex_in,
    input  wire logic signed [31:0] ey_in,
    input  wire logic signed [31:0] ez_in,
    input  wire logic signed [31:0] bx_in,
    input  wire logic signed [31:0] by_in,
    input  wire logic signed [31:0] bz_in,
    input  wire logic [31:0]        rel_eps,
    input  wire logic [31:0]        rel_mu,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              reply_kind,
    output logic signed [31:0]      ex_out,
    output logic signed [31:0]      ey_out,
    output logic signed [31:0]      ez_out,
    output logic signed [31:0]      bx_out,
    output logic signed [31:0]      by_out,
    output logic signed [31:0]      bz_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import fdtd_pkg::*;

    localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(CELLS);
    localparam int MXY   = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
    localparam int MAXC  = (MXY > MAX_Z) ? MXY : MAX_Z;
    localparam int CW    = $clog2(MAXC + 1);

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'(32'(x) * (MAX_Y * MAX_Z) + 32'(y) * MAX_Z + 32'(z));
    endfunction

    // configuration
    uword_t     dt_reg, inv_dx_reg, inv_dy_reg, inv_dz_reg;
    logic [4:0] size_x_reg, size_y_reg, size_z_reg;

    // accepted item
    logic [1:0] req_reg;
    logic [3:0] cx_reg, cy_reg, cz_reg;
    sword_t     fld_reg [6];
    uword_t     eps_reg, mu_reg;

    // control
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;
    logic            mode_b_reg, mode_b_next;
    logic [2:0]      rd_n_reg, rd_n_next;
    logic [3:0]      u_reg, u_next;
    logic [1:0]      face_reg, face_next;
    logic [CW-1:0]   mp_reg, mp_next, mq_reg, mq_next;
    logic            side_reg, side_next;
    logic            out_valid_reg, out_valid_next;

    // datapath
    sword_t            src_reg [3], src_next [3];
    sword_t            dst_reg [3], dst_next [3];
    sword_t            nb_reg [3][3], nb_next [3][3];
    sword_t            da_reg [3], da_next [3];
    sword_t            db_reg [3], db_next [3];
    sword_t            res_reg [3], res_next [3];
    uword_t            inv_reg, inv_next;
    sword_t            q1_reg, q1_next;
    sword_t            acc_reg, acc_next;
    sword_t            curl_reg, curl_next;
    logic signed [64:0] prod_reg, prod_next;
    uword_t            ieps_reg, ieps_next, imu_reg, imu_next;
    logic [1:0]        rk_reg, rk_next;
    sword_t            rf_reg [6], rf_next [6];
    logic [1:0]        kind_out_reg, kind_out_next;
    sword_t            fout_reg [6], fout_next [6];

    // memory: lanes ex ey ez bx by bz inv_eps inv_mu
    logic [7:0][31:0] mem [CELLS];
    logic [7:0][31:0] mem_q;
    logic [7:0][31:0] mem_wd;
    logic [7:0]       mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;

    // reciprocal unit
    logic   div_start, div_done;
    uword_t div_den, div_quot;

    // effective sizes and derived coordinates
    logic [CW-1:0] nx, ny, nz, hx, hy, hz, lo;
    logic [CW-1:0] rx, ry, rz;
    logic [CW-1:0] mdx, mdy, mdz, msx, msy, msz;
    logic [CW-1:0] dfx, dfy, dfz, sfx, sfy, sfz, pmax, qmax;
    logic          cell_ok;
    logic [AW-1:0] cell_at;
    logic [1:0]    m;
    logic [1:0]    ph;
    sword_t        opa, sp;
    uword_t        opb, ia, ib;

    assign nx = (size_x_reg < 5'd3) ? CW'(3) :
                ((32'(size_x_reg) > MAX_X) ? CW'(MAX_X) : CW'(size_x_reg));
    assign ny = (size_y_reg < 5'd3) ? CW'(3) :
                ((32'(size_y_reg) > MAX_Y) ? CW'(MAX_Y) : CW'(size_y_reg));
    assign nz = (size_z_reg < 5'd3) ? CW'(3) :
                ((32'(size_z_reg) > MAX_Z) ? CW'(MAX_Z) : CW'(size_z_reg));
    assign hx = nx - CW'(2);
    assign hy = ny - CW'(2);
    assign hz = nz - CW'(2);
    assign lo = mode_b_reg ? CW'(0) : CW'(1);

    assign cell_ok = (32'(cx_reg) < MAX_X) && (32'(cy_reg) < MAX_Y) && (32'(cz_reg) < MAX_Z);
    assign cell_at = AW'(32'(cx_reg) * (MAX_Y * MAX_Z) + 32'(cy_reg) * MAX_Z + 32'(cz_reg));

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dt_reg        <= Q_ONE;
            inv_dx_reg    <= Q_ONE;
            inv_dy_reg    <= Q_ONE;
            inv_dz_reg    <= Q_ONE;
            size_x_reg    <= 5'd16;
            size_y_reg    <= 5'd16;
            size_z_reg    <= 5'd16;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_DT:        dt_reg        <= cfg_data;
                REG_INV_DX:    inv_dx_reg    <= cfg_data;
                REG_INV_DY:    inv_dy_reg    <= cfg_data;
                REG_INV_DZ:    inv_dz_reg    <= cfg_data;
                REG_SIZE_X:    size_x_reg    <= cfg_data[4:0];
                REG_SIZE_Y:    size_y_reg    <= cfg_data[4:0];
                REG_SIZE_Z:    size_z_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            req_reg    <= req_type;
            cx_reg     <= cell_x;
            cy_reg     <= cell_y;
            cz_reg     <= cell_z;
            fld_reg[0] <= ex_in;
            fld_reg[1] <= ey_in;
            fld_reg[2] <= ez_in;
            fld_reg[3] <= bx_in;
            fld_reg[4] <= by_in;
            fld_reg[5] <= bz_in;
            eps_reg    <= rel_eps;
            mu_reg     <= rel_mu;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 8; l++) begin
            if (mem_we[l]) begin
                mem[mem_wa][l] <= mem_wd[l];
            end
        end
        mem_q <= mem[mem_ra];
    end

    assign div_den = (state_reg == ST_REQ) ? eps_reg : mu_reg;

    fdtd_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // sweep and mirror coordinates
    always_comb
    begin
        rx = ci_reg;
        ry = cj_reg;
        rz = ck_reg;
        case (rd_n_reg)
            3'd1: rx = mode_b_reg ? ci_reg + CW'(1) : ci_reg - CW'(1);
            3'd2: ry = mode_b_reg ? cj_reg + CW'(1) : cj_reg - CW'(1);
            3'd3: rz = mode_b_reg ? ck_reg + CW'(1) : ck_reg - CW'(1);
            default: ;
        endcase

        dfx = side_reg ? nx - CW'(1) : CW'(0);
        dfy = side_reg ? ny - CW'(1) : CW'(0);
        dfz = side_reg ? nz - CW'(1) : CW'(0);
        sfx = side_reg ? hx : CW'(1);
        sfy = side_reg ? hy : CW'(1);
        sfz = side_reg ? hz : CW'(1);
        case (face_reg)
            AX_X:
            begin
                mdx = dfx;    mdy = mp_reg; mdz = mq_reg;
                msx = sfx;    msy = mp_reg; msz = mq_reg;
                pmax = ny;    qmax = nz;
            end
            AX_Y:
            begin
                mdx = mp_reg; mdy = dfy;    mdz = mq_reg;
                msx = mp_reg; msy = sfy;    msz = mq_reg;
                pmax = nx;    qmax = nz;
            end
            default:
            begin
                mdx = mp_reg; mdy = mq_reg; mdz = dfz;
                msx = mp_reg; msy = mq_reg; msz = sfz;
                pmax = nx;    qmax = ny;
            end
        endcase
    end

    // multiplier operands
    assign m  = u_reg[3:2];
    assign ph = u_reg[1:0];
    assign sp = sat_prod(prod_reg);

    always_comb
    begin
        case (m)
            2'd0:    begin ia = inv_dy_reg; ib = inv_dz_reg; end
            2'd1:    begin ia = inv_dz_reg; ib = inv_dx_reg; end
            default: begin ia = inv_dx_reg; ib = inv_dy_reg; end
        endcase
        case (ph)
            2'd0:    begin opa = da_reg[m]; opb = ia; end
            2'd1:    begin opa = db_reg[m]; opb = ib; end
            2'd2:    begin opa = curl_reg;  opb = dt_reg; end
            default: begin opa = acc_reg;   opb = inv_reg; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        ck_next        = ck_reg;
        mode_b_next    = mode_b_reg;
        rd_n_next      = rd_n_reg;
        u_next         = u_reg;
        face_next      = face_reg;
        mp_next        = mp_reg;
        mq_next        = mq_reg;
        side_next      = side_reg;
        out_valid_next = out_valid_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        nb_next        = nb_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        res_next       = res_reg;
        inv_next       = inv_reg;
        q1_next        = q1_reg;
        acc_next       = acc_reg;
        curl_next      = curl_reg;
        prod_next      = prod_reg;
        ieps_next      = ieps_reg;
        imu_next       = imu_reg;
        rk_next        = rk_reg;
        rf_next        = rf_reg;
        kind_out_next  = kind_out_reg;
        fout_next      = fout_reg;
        mem_we         = '0;
        mem_wa         = cell_at;
        mem_wd         = '0;
        mem_ra         = cell_at;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                mem_we             = '1;
                mem_wa             = clr_reg;
                mem_wd[LN_IEPS]    = Q_ONE;
                mem_wd[LN_IMU]     = Q_ONE;
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
                else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_REQ;
                end
            end
            ST_REQ:
            begin
                rk_next = req_reg;
                for (int l = 0; l < 6; l++) begin
                    rf_next[l] = '0;
                end
                case (req_reg)
                    REQ_WRITE:
                    begin
                        if (cell_ok) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_E;
                        end
                        else begin
                            state_next = ST_DONE;
                        end
                    end
                    REQ_READ:
                    begin
                        state_next = ST_RDC;
                    end
                    REQ_STEP:
                    begin
                        mode_b_next = 1'b0;
                        ci_next     = CW'(1);
                        cj_next     = CW'(1);
                        ck_next     = CW'(1);
                        rd_n_next   = '0;
                        state_next  = ST_EB_RD;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_RDC:
            begin
                if (cell_ok) begin
                    for (int l = 0; l < 6; l++) begin
                        rf_next[l] = mem_q[l];
                    end
                end
                state_next = ST_DONE;
            end
            ST_DIV_E:
            begin
                if (div_done) begin
                    ieps_next  = div_quot;
                    div_start  = 1'b1;
                    state_next = ST_DIV_M;
                end
            end
            ST_DIV_M:
            begin
                if (div_done) begin
                    imu_next   = div_quot;
                    state_next = ST_WCELL;
                end
            end
            ST_WCELL:
            begin
                mem_we = '1;
                for (int l = 0; l < 6; l++) begin
                    mem_wd[l] = fld_reg[l];
                end
                mem_wd[LN_IEPS] = ieps_reg;
                mem_wd[LN_IMU]  = imu_reg;
                state_next      = ST_DONE;
            end
            ST_EB_RD:
            begin
                mem_ra    = cell_addr(rx, ry, rz);
                rd_n_next = rd_n_reg + 3'd1;
                if (rd_n_reg == 3'd1) begin
                    for (int l = 0; l < 3; l++) begin
                        src_next[l] = mode_b_reg ? mem_q[LN_EX + l] : mem_q[LN_BX + l];
                        dst_next[l] = mode_b_reg ? mem_q[LN_BX + l] : mem_q[LN_EX + l];
                    end
                    inv_next = mode_b_reg ? mem_q[LN_IMU] : mem_q[LN_IEPS];
                end
                else if (rd_n_reg >= 3'd2) begin
                    for (int l = 0; l < 3; l++) begin
                        nb_next[2'(rd_n_reg - 3'd2)][l] =
                            mode_b_reg ? mem_q[LN_EX + l] : mem_q[LN_BX + l];
                    end
                end
                if (rd_n_reg == 3'd4) begin
                    state_next = ST_EB_DIF;
                end
            end
            ST_EB_DIF:
            begin
                // backward differences of B for E, forward differences of E for B
                if (mode_b_reg) begin
                    da_next[0] = sub_sat(nb_reg[1][2], src_reg[2]);
                    db_next[0] = sub_sat(nb_reg[2][1], src_reg[1]);
                    da_next[1] = sub_sat(nb_reg[2][0], src_reg[0]);
                    db_next[1] = sub_sat(nb_reg[0][2], src_reg[2]);
                    da_next[2] = sub_sat(nb_reg[0][1], src_reg[1]);
                    db_next[2] = sub_sat(nb_reg[1][0], src_reg[0]);
                end
                else begin
                    da_next[0] = sub_sat(src_reg[2], nb_reg[1][2]);
                    db_next[0] = sub_sat(src_reg[1], nb_reg[2][1]);
                    da_next[1] = sub_sat(src_reg[0], nb_reg[2][0]);
                    db_next[1] = sub_sat(src_reg[2], nb_reg[0][2]);
                    da_next[2] = sub_sat(src_reg[1], nb_reg[0][1]);
                    db_next[2] = sub_sat(src_reg[0], nb_reg[1][0]);
                end
                u_next     = '0;
                state_next = ST_EB_MUL;
            end
            ST_EB_MUL:
            begin
                prod_next  = $signed(opa) * $signed({1'b0, opb});
                state_next = ST_EB_SAT;
            end
            ST_EB_SAT:
            begin
                case (ph)
                    2'd0:
                    begin
                        q1_next    = sp;
                        u_next     = u_reg + 4'd1;
                        state_next = ST_EB_MUL;
                    end
                    2'd1:
                    begin
                        acc_next   = sp;
                        state_next = ST_EB_CURL;
                    end
                    2'd2:
                    begin
                        acc_next   = sp;
                        u_next     = u_reg + 4'd1;
                        state_next = ST_EB_MUL;
                    end
                    default:
                    begin
                        acc_next   = sp;
                        state_next = ST_EB_ACC;
                    end
                endcase
            end
            ST_EB_CURL:
            begin
                curl_next  = sub_sat(q1_reg, acc_reg);
                u_next     = u_reg + 4'd1;
                state_next = ST_EB_MUL;
            end
            ST_EB_ACC:
            begin
                res_next[m] = mode_b_reg ? sub_sat(dst_reg[m], acc_reg)
                                         : add_sat(dst_reg[m], acc_reg);
                if (u_reg == 4'd11) begin
                    state_next = ST_EB_WR;
                end
                else begin
                    u_next     = u_reg + 4'd1;
                    state_next = ST_EB_MUL;
                end
            end
            ST_EB_WR:
            begin
                mem_wa = cell_addr(ci_reg, cj_reg, ck_reg);
                mem_we = mode_b_reg ? 8'b0011_1000 : 8'b0000_0111;
                for (int l = 0; l < 3; l++) begin
                    mem_wd[LN_EX + l] = res_reg[l];
                    mem_wd[LN_BX + l] = res_reg[l];
                end
                rd_n_next  = '0;
                state_next = ST_EB_RD;
                if (ck_reg != hz) begin
                    ck_next = ck_reg + CW'(1);
                end
                else begin
                    ck_next = lo;
                    if (cj_reg != hy) begin
                        cj_next = cj_reg + CW'(1);
                    end
                    else begin
                        cj_next = lo;
                        if (ci_reg != hx) begin
                            ci_next = ci_reg + CW'(1);
                        end
                        else if (mode_b_reg) begin
                            state_next = ST_DONE;
                        end
                        else begin
                            face_next  = AX_X;
                            mp_next    = '0;
                            mq_next    = '0;
                            side_next  = 1'b0;
                            state_next = ST_MIR_RD;
                        end
                    end
                end
            end
            ST_MIR_RD:
            begin
                mem_ra     = cell_addr(msx, msy, msz);
                state_next = ST_MIR_WR;
            end
            ST_MIR_WR:
            begin
                mem_wa = cell_addr(mdx, mdy, mdz);
                mem_we = 8'b0000_0111;
                for (int l = 0; l < 3; l++) begin
                    mem_wd[LN_EX + l] = neg_sat(mem_q[LN_EX + l]);
                end
                state_next = ST_MIR_RD;
                if (!side_reg) begin
                    side_next = 1'b1;
                end
                else begin
                    side_next = 1'b0;
                    if (mq_reg != qmax - CW'(1)) begin
                        mq_next = mq_reg + CW'(1);
                    end
                    else begin
                        mq_next = '0;
                        if (mp_reg != pmax - CW'(1)) begin
                            mp_next = mp_reg + CW'(1);
                        end
                        else begin
                            mp_next = '0;
                            if (face_reg == AX_Z) begin
                                mode_b_next = 1'b1;
                                ci_next     = '0;
                                cj_next     = '0;
                                ck_next     = '0;
                                rd_n_next   = '0;
                                state_next  = ST_EB_RD;
                            end
                            else begin
                                face_next = face_reg + 2'd1;
                            end
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    kind_out_next  = rk_reg;
                    fout_next      = rf_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            mode_b_reg    <= 1'b0;
            rd_n_reg      <= '0;
            u_reg         <= '0;
            face_reg      <= AX_X;
            mp_reg        <= '0;
            mq_reg        <= '0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            ck_reg        <= ck_next;
            mode_b_reg    <= mode_b_next;
            rd_n_reg      <= rd_n_next;
            u_reg         <= u_next;
            face_reg      <= face_next;
            mp_reg        <= mp_next;
            mq_reg        <= mq_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        nb_reg       <= nb_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        res_reg      <= res_next;
        inv_reg      <= inv_next;
        q1_reg       <= q1_next;
        acc_reg      <= acc_next;
        curl_reg     <= curl_next;
        prod_reg     <= prod_next;
        ieps_reg     <= ieps_next;
        imu_reg      <= imu_next;
        rk_reg       <= rk_next;
        rf_reg       <= rf_next;
        kind_out_reg <= kind_out_next;
        fout_reg     <= fout_next;
    end

    assign out_valid  = out_valid_reg;
    assign reply_kind = kind_out_reg;
    assign ex_out     = fout_reg[0];
    assign ey_out     = fout_reg[1];
    assign ez_out     = fout_reg[2];
    assign bx_out     = fout_reg[3];
    assign by_out     = fout_reg[4];
    assign bz_out     = fout_reg[5];

`ifndef SYNTHESIS
    a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EB_WR) |-> (ci_reg <= hx && cj_reg <= hy && ck_reg <= hz))
        else $error("sweep counter beyond active grid");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_E || state_reg == ST_DIV_M))
        else $error("reciprocal finished with no write waiting");
`endif

endmodule

`default_nettype wire
